// ----- sv/serm_pkg.sv -----
// Shared types, constants and the distance conversion for the sonar echo range monitor.
package serm_pkg;

  localparam int SeqW     = 16;
  localparam int WidthW   = 16;
  localparam int DistW    = 11;
  localparam int OutDistW = 12;
  localparam int MissW    = 8;
  localparam int StopW    = 11;
  localparam int LimitW   = 8;
  localparam int AddrW    = 4;
  localparam int DataW    = 32;
  localparam int InTdataW  = 32;
  localparam int OutTdataW = 56;

  // floor(w*10/583) == (w * ceil(2^30/583)*10) >> 30 for every 16-bit w
  localparam int MulW       = 25;
  localparam int DistShift  = 30;
  localparam int ProdW      = WidthW + MulW;
  localparam logic [MulW-1:0] DistMul = 25'd18417530;

  localparam logic [MissW-1:0]    MissMax     = '1;
  localparam logic [DistW-1:0]    ClosestNone = '1;
  localparam logic [OutDistW-1:0] DistNone    = '1;

  localparam logic [WidthW-1:0] MinEchoRst   = 16'd60;
  localparam logic [StopW-1:0]  StopRst      = 11'd300;
  localparam logic [LimitW-1:0] MissLimitRst = 8'd5;

  typedef enum logic [1:0] {
    RegMinEcho   = 2'd0,
    RegStopDist  = 2'd1,
    RegMissLimit = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [WidthW-1:0] echo_floor_us;
    logic [StopW-1:0]  stop_distance_mm;
    logic [LimitW-1:0] miss_limit;
  } cfg_t;

  typedef struct packed {
    logic [SeqW-1:0]  last_sequence;
    logic [MissW-1:0] miss_count;
    logic [DistW-1:0] closest_seen;
  } state_t;

  typedef struct packed {
    logic [OutDistW-1:0] nearest_mm;
    logic                blind;
    logic                too_close;
    logic [MissW-1:0]    miss_run;
    logic [WidthW-1:0]   echo_used_us;
    logic [OutDistW-1:0] distance_mm;
  } result_t;

  function automatic logic [DistW-1:0] echo_to_mm(input logic [WidthW-1:0] width);
    logic [ProdW-1:0] prod;
    prod = ProdW'(width) * ProdW'(DistMul);
    return prod[DistShift +: DistW];
  endfunction

endpackage

// ----- sv/serm_calc.sv -----
// Per-period evaluation: distance, miss run, flags and next tracking state.
module serm_calc
  import serm_pkg::*;
(
  input  cfg_t              cfg_i,
  input  state_t            state_i,
  input  logic [SeqW-1:0]   seq_i,
  input  logic [WidthW-1:0] width_i,
  output state_t            state_o,
  output result_t           res_o
);

  logic             new_echo;
  logic             hit;
  logic [DistW-1:0] range_mm;
  logic [MissW-1:0] miss_d;
  logic [DistW-1:0] closest_d;

  assign new_echo = (seq_i != state_i.last_sequence);
  assign hit      = new_echo && (width_i >= cfg_i.echo_floor_us);
  assign range_mm = echo_to_mm(width_i);

  always_comb begin
    if (hit) begin
      miss_d = '0;
    end else if (state_i.miss_count != MissMax) begin
      miss_d = state_i.miss_count + MissW'(1);
    end else begin
      miss_d = state_i.miss_count;
    end
  end

  assign closest_d = (hit && (range_mm < state_i.closest_seen)) ? range_mm
                                                                : state_i.closest_seen;

  assign state_o.last_sequence = new_echo ? seq_i : state_i.last_sequence;
  assign state_o.miss_count    = miss_d;
  assign state_o.closest_seen  = closest_d;

  assign res_o.distance_mm  = hit ? {1'b0, range_mm} : DistNone;
  assign res_o.echo_used_us = new_echo ? width_i : '0;
  assign res_o.miss_run     = miss_d;
  assign res_o.too_close    = hit && (range_mm < cfg_i.stop_distance_mm);
  assign res_o.blind        = (miss_d >= cfg_i.miss_limit);
  assign res_o.nearest_mm   = (closest_d == ClosestNone) ? DistNone : {1'b0, closest_d};

endmodule

// ----- sv/sonar_echo_range_monitor_core.sv -----
// Top level of the sonar echo range monitor: stream ports, APB registers, result register.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata[31:0]  one loop period
//  m_axis    out  m_axis_tvalid/tready      tdata[55:0]  one result per period
//  apb       in   psel/penable/pready       3 registers at 0x0, 0x4, 0x8
//
// One transaction per cycle unless m_axis stalls; path: input register, result register.
// Throughput is set by the single evaluation stage between the two registers.
// rst_ni loads the register defaults, resets the tracking state and clears both valid flags.
// A stalled result holds in the result register; the input register still takes one
// more transaction, then s_axis_tready drops until the result drains.
module sonar_echo_range_monitor_core
  import serm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [15:0] sequence_count, [31:16] echo_width_us
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [11:0] distance_mm, [27:12] echo_used_us, [35:28] miss_run, [36] too_close,
  // [37] blind, [49:38] nearest_mm, [55:50] zero
  output logic [OutTdataW-1:0] m_axis_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [DataW-1:0]     pwdata,
  output logic [DataW-1:0]     prdata,
  output logic                 pready
);

  cfg_t              cfg_q;
  state_t            state_q, state_d;
  result_t           res_d, out_q;
  logic              in_valid_q, out_valid_q;
  logic [SeqW-1:0]   in_seq_q;
  logic [WidthW-1:0] in_width_q;
  logic              advance;
  logic              cfg_wr;
  reg_idx_e          reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    case (reg_idx)
      RegMinEcho:   prdata = DataW'(cfg_q.echo_floor_us);
      RegStopDist:  prdata = DataW'(cfg_q.stop_distance_mm);
      RegMissLimit: prdata = DataW'(cfg_q.miss_limit);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.echo_floor_us    <= MinEchoRst;
      cfg_q.stop_distance_mm <= StopRst;
      cfg_q.miss_limit       <= MissLimitRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegMinEcho:   cfg_q.echo_floor_us    <= pwdata[WidthW-1:0];
        RegStopDist:  cfg_q.stop_distance_mm <= pwdata[StopW-1:0];
        RegMissLimit: cfg_q.miss_limit       <= pwdata[LimitW-1:0];
        default: ;
      endcase
    end
  end

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;

  serm_calc u_calc (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .seq_i   (in_seq_q),
    .width_i (in_width_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q            <= 1'b0;
      out_valid_q           <= 1'b0;
      state_q.last_sequence <= '0;
      state_q.miss_count    <= '0;
      state_q.closest_seen  <= ClosestNone;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_seq_q   <= s_axis_tdata[SeqW-1:0];
      in_width_q <= s_axis_tdata[SeqW +: WidthW];
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tdata = {(OutTdataW - $bits(result_t))'(0), out_q};

  a_hit_clears_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.distance_mm != DistNone) |-> (out_q.miss_run == '0))
    else $error("reading did not clear miss run");

  a_close_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.too_close) |-> (out_q.distance_mm != DistNone))
    else $error("too_close without a reading");

  a_closest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.distance_mm != DistNone)
      |-> (out_q.nearest_mm <= out_q.distance_mm && out_q.nearest_mm != DistNone))
    else $error("closest distance above current reading");

  a_state_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("tracking state changed without a transaction");

endmodule

// ----- tb/sv/tb_sonar_echo_range_monitor_core.sv -----
// Testbench for the sonar echo range monitor: stream stimulus, register writes, result checking.
module tb_sonar_echo_range_monitor_core
  import serm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          EchoScale  = 10;
  localparam int          EchoDiv    = 583;
  localparam int          CycleLimit = 400000;
  localparam logic [1:0]  RegUnused  = 2'd3;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // [15:0] sequence_count, [31:16] echo_width_us
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [11:0] distance_mm, [27:12] echo_used_us, [35:28] miss_run, [36] too_close,
  // [37] blind, [49:38] nearest_mm, [55:50] zero
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [AddrW-1:0]     paddr         = '0;
  logic [DataW-1:0]     pwdata        = '0;
  logic [DataW-1:0]     prdata;
  logic                 pready;

  cfg_t    cfg_now;
  state_t  track;
  result_t pending_ranges[$];

  int  mismatches    = 0;
  int  periods_sent  = 0;
  int  results_seen  = 0;
  int  reg_writes    = 0;
  int  cycles        = 0;
  int  ready_hold    = 0;
  bit  steady        = 1'b0;

  sonar_echo_range_monitor_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_ranges.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] MISMATCH %s", $realtime, msg);
  endfunction

  function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got)
      flag_error($sformatf("%s: expected %0h, got %0h", field, want, got));
  endfunction

  // mostly short idles, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // One loop period through the range logic; updates the tracked state.
  function automatic result_t range_predict(logic [SeqW-1:0] seq, logic [WidthW-1:0] width);
    result_t     r;
    logic        valid;
    int unsigned range_mm;
    r        = '0;
    valid    = 1'b0;
    range_mm = 0;
    if (seq != track.last_sequence) begin
      track.last_sequence = seq;
      r.echo_used_us      = width;
      if (width >= cfg_now.echo_floor_us) begin
        range_mm         = (32'(width) * EchoScale) / EchoDiv;
        valid            = 1'b1;
        track.miss_count = '0;
        if (range_mm < track.closest_seen) track.closest_seen = DistW'(range_mm);
      end
    end
    if (!valid && track.miss_count != MissMax) track.miss_count++;
    r.distance_mm = valid ? OutDistW'(range_mm) : DistNone;
    r.miss_run    = track.miss_count;
    r.too_close   = valid && (range_mm < cfg_now.stop_distance_mm);
    r.blind       = track.miss_count >= cfg_now.miss_limit;
    r.nearest_mm  = (track.closest_seen == ClosestNone) ? DistNone
                                                        : OutDistW'(track.closest_seen);
    return r;
  endfunction

  // result side: check each transaction, stall tready at random
  always @(posedge clk_i) begin : result_side
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got = m_axis_tdata[$bits(result_t)-1:0];
        if (pending_ranges.size() == 0) begin
          flag_error($sformatf("result with nothing expected: %0h", m_axis_tdata));
        end else begin
          want = pending_ranges.pop_front();
          compare_field("distance_mm", 16'(want.distance_mm), 16'(got.distance_mm));
          compare_field("echo_used_us", want.echo_used_us, got.echo_used_us);
          compare_field("miss_run", 16'(want.miss_run), 16'(got.miss_run));
          compare_field("too_close", 16'(want.too_close), 16'(got.too_close));
          compare_field("blind", 16'(want.blind), 16'(got.blind));
          compare_field("nearest_mm", 16'(want.nearest_mm), 16'(got.nearest_mm));
          compare_field("tdata pad", 16'(m_axis_tdata[OutTdataW-1:$bits(result_t)]), 16'd0);
        end
      end
      if (ready_hold > 0) begin
        m_axis_tready <= 1'b0;
        ready_hold--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 20) ready_hold = idle_len();
      end
    end
  end

  task automatic send_period(logic [SeqW-1:0] seq, logic [WidthW-1:0] width);
    int gap;
    gap = (steady || $urandom_range(0, 99) < 50) ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {width, seq};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_ranges.push_back(range_predict(seq, width));
    periods_sent++;
  endtask

  // stop the input side and let every result drain
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (pending_ranges.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [DataW-1:0] value);
    quiesce();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    reg_writes++;
    case (idx)
      RegMinEcho:   cfg_now.echo_floor_us    = value[WidthW-1:0];
      RegStopDist:  cfg_now.stop_distance_mm = value[StopW-1:0];
      RegMissLimit: cfg_now.miss_limit       = value[LimitW-1:0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx != RegUnused) begin
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      case (idx)
        RegMinEcho:   compare_field("echo floor readback", cfg_now.echo_floor_us,
                                    prdata[15:0]);
        RegStopDist:  compare_field("stop_distance_mm readback",
                                    16'(cfg_now.stop_distance_mm), prdata[15:0]);
        default:      compare_field("miss_limit readback", 16'(cfg_now.miss_limit),
                                    prdata[15:0]);
      endcase
      penable <= 1'b0;
    end
    psel    <= 1'b0;
  endtask

  task automatic apply_cfg(int min_echo, int stop_mm, int limit);
    cfg_write(RegMinEcho, DataW'(min_echo));
    cfg_write(RegStopDist, DataW'(stop_mm));
    cfg_write(RegMissLimit, DataW'(limit));
  endtask

  function automatic logic [SeqW-1:0] pick_seq();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return track.last_sequence + 16'd1;
    if (r < 72) return track.last_sequence;
    if (r < 88) return 16'($urandom);
    return track.last_sequence - 16'($urandom_range(1, 3));
  endfunction

  function automatic logic [WidthW-1:0] pick_width();
    int r;
    int w;
    r = $urandom_range(0, 99);
    if (r < 35) return 16'($urandom);
    if (r < 65) begin
      w = int'(cfg_now.echo_floor_us) + int'($urandom_range(0, 4)) - 2;
      if (w < 0) w = 0;
      if (w > 65535) w = 65535;
      return 16'(w);
    end
    return 16'($urandom_range(1000, 20000));
  endfunction

  task automatic test_defaults_directed();
    send_period(16'h0000, 16'd1000);   // unchanged count after reset: miss
    send_period(16'h0001, 16'd59);     // new echo just below floor
    send_period(16'h0002, 16'd65535);  // widest echo, farthest distance
    send_period(16'h0002, 16'd5000);   // no new echo
    send_period(16'h0003, 16'd17490);  // exactly at stop distance
    send_period(16'h0004, 16'd17489);  // one below stop distance
    send_period(16'hFFFF, 16'd0);      // zero width, below floor
    send_period(16'h0000, 16'd12000);  // counter wrap
    send_period(16'h0000, 16'd12000);
    send_period(16'h0000, 16'd12000);
    send_period(16'h0000, 16'd12000);
    send_period(16'h0000, 16'd12000);
    send_period(16'h0000, 16'd12000);  // miss run reaches default limit
  endtask

  task automatic test_floor_and_limits();
    cfg_write(RegUnused, 32'h0000_0001);  // unmapped register, ignored
    apply_cfg(5000, 0, 0);
    send_period(16'h0010, 16'd4999);   // below floor, blind with zero limit
    send_period(16'h0011, 16'd5000);   // at floor, valid, still blind
    apply_cfg(5000, 2047, 255);
    send_period(16'h0012, 16'd5001);   // every valid distance too close
    send_period(16'h0012, 16'd5001);
    apply_cfg(5000, 300, 1);
    send_period(16'h0013, 16'd8000);
    send_period(16'h0013, 16'd8000);   // single miss reaches limit
  endtask

  task automatic test_random_mix(int count, int min_echo, int stop_mm, int limit);
    apply_cfg(min_echo, stop_mm, limit);
    for (int i = 0; i < count; i++) begin
      steady = (i < count / 4);
      send_period(pick_seq(), pick_width());
    end
    steady = 1'b0;
  endtask

  task automatic test_outage();
    apply_cfg(40000, 1024, 255);
    send_period(track.last_sequence + 16'd1, 16'd50000);
    for (int i = 0; i < 270; i++) begin
      if ($urandom_range(0, 99) < 70)
        send_period(track.last_sequence, 16'($urandom));
      else
        send_period(track.last_sequence + 16'($urandom_range(1, 65535)),
                    16'($urandom_range(0, 39999)));
    end
    send_period(track.last_sequence + 16'd1, 16'($urandom_range(40000, 65535)));
  endtask

  task automatic test_zero_floor();
    apply_cfg(65535, 1124, 5);
    send_period(track.last_sequence + 16'd1, 16'd65534);
    send_period(track.last_sequence + 16'd1, 16'd65535);
    apply_cfg(0, 1, 5);
    send_period(track.last_sequence + 16'd1, 16'd0);   // zero width valid, closest zero
    send_period(track.last_sequence + 16'd1, 16'd582);
    send_period(track.last_sequence + 16'd1, 16'd583);
  endtask

  initial begin
    cfg_now = '{MinEchoRst, StopRst, MissLimitRst};
    track   = '{'0, '0, ClosestNone};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults_directed();
    test_floor_and_limits();
    test_random_mix(150, 60, 300, 5);
    test_random_mix(100, 1000, 2047, 1);
    test_random_mix(60, 65535, 0, 255);
    repeat (3)
      test_random_mix(50, $urandom_range(0, 20000), $urandom_range(0, 2047),
                      $urandom_range(0, 255));
    test_outage();
    test_zero_floor();

    quiesce();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d echo periods, checked %0d results, %0d register writes,", periods_sent,
             results_seen, reg_writes);
    $display("covering floor, stop and miss limit extremes and miss run saturation.");
    if (mismatches == 0 && pending_ranges.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/serm_pkg.sv
sv/serm_calc.sv
sv/sonar_echo_range_monitor_core.sv
tb/sv/tb_sonar_echo_range_monitor_core.sv
